### sv/sequential_list_table_defines.svh
// ----------------------------------------------------------------------------
// Sequential list table assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_TABLE_DEFINES_SVH
`define SEQUENTIAL_LIST_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SLT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sltab_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list table package
// Sizes, codes and record types shared by the list table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sltab_pkg;

    localparam int DEPTH = 128;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 8;
    localparam int XW    = (CW > PW) ? CW : PW;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4,
        OP_FIND   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_RDWAIT,
        S_FIND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] name_low;
        logic [63:0] name_mid;
        logic [31:0] name_high;
        logic [7:0]  age;
    } t_rec;

    localparam int RW = $bits(t_rec);

    typedef struct packed {
        logic [2:0]    op;
        logic [PW-1:0] position;
        logic [63:0]   entry_key;
        logic [63:0]   name_low;
        logic [63:0]   name_mid;
        logic [31:0]   name_high;
        logic [7:0]    age_in;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [PW-1:0] found_position;
        logic [63:0]   out_key;
        logic [63:0]   out_name_low;
        logic [63:0]   out_name_mid;
        logic [31:0]   out_name_high;
        logic [7:0]    out_age;
        logic [PW-1:0] list_length;
    } t_rsp;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_rec          wdata;
        logic [AW-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

### sv/sltab_req_if.sv
// ----------------------------------------------------------------------------
// Sequential list table request channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sltab_req_if;
    logic              valid;
    logic              ready;
    sltab_pkg::t_req   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/sltab_rsp_if.sv
// ----------------------------------------------------------------------------
// Sequential list table response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sltab_rsp_if;
    logic              valid;
    logic              ready;
    sltab_pkg::t_rsp   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/sequential_list_table.sv
// Sequential list table: ordered table of up to DEPTH records at positions
// 1..length, each a 64-bit key, a 20-byte name and an 8-bit age.
// Request channel i_req carries one operation per beat (clear, append,
// insert, delete, read, find); response channel o_rsp returns exactly one
// result beat per request, with status and the length after the operation.
// Clear, append and unused codes go straight to the result; read waits for
// the registered RAM read. Insert, delete and find walk the record RAM one
// entry per cycle through its single read and single write port; insert
// then writes the new record. A new request is taken in the cycle after
// the previous result moves to the output register.
// Reset clears the length and the handshake state; record storage is not
// cleared and needs no clearing pass. When the receiver stalls, the result
// holds in the output register while the next request is still processed;
// that request's result then waits in the controller.
// ----------------------------------------------------------------------------
// Sequential list table top level
// Record RAM, operation controller and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sltab_req_if.sink   i_req,
    sltab_rsp_if.source o_rsp
);
    import sltab_pkg::*;

    t_ram_req        ram_req;
    logic [RW-1:0]   ram_rdata;
    logic            done;
    logic            res_ready;
    t_rsp            ctrl_rsp;

    logic            r_out_vld, n_out_vld;
    t_rsp            r_out;

    sltab_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    sltab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.payload),
        .o_req_ready (i_req.ready),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_done      (done),
        .o_rsp       (ctrl_rsp),
        .i_res_ready (res_ready)
    );

    // Take a new result when the output register is empty or draining.
    assign res_ready = !r_out_vld || o_rsp.ready;

    always_comb begin
        n_out_vld = r_out_vld && !o_rsp.ready;
        if (done && res_ready) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && res_ready) begin
            r_out <= ctrl_rsp;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

`default_nettype wire

### sv/sltab_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sltab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/sltab_ctrl.sv
// ----------------------------------------------------------------------------
// Sequential list table controller
// Decodes operations, walks the record RAM for shifts and key search.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sequential_list_table_defines.svh"

module sltab_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    input  wire sltab_pkg::t_req      i_req,
    output logic                      o_req_ready,
    output sltab_pkg::t_ram_req       o_ram,
    input  wire sltab_pkg::t_rec      i_rdata,
    output logic                      o_done,
    output sltab_pkg::t_rsp           o_rsp,
    input  wire logic                 i_res_ready
);
    import sltab_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_op, n_op;
    t_rec          r_new, n_new;
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_stop, n_stop;
    t_status       r_status, n_status;
    logic          r_hit, n_hit;
    logic [CW-1:0] r_found, n_found;
    t_rec          r_rec, n_rec;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          pos_ok;
    logic          full;
    logic [AW-1:0] pos_a;
    logic [AW-1:0] last_a;
    t_rec          rec_in;
    logic          key_hit;

    assign pos_x   = XW'(i_req.position);
    assign cnt_x   = XW'(r_count);
    assign pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
    assign full    = (r_count == CW'(DEPTH));
    assign pos_a   = AW'(pos_x - XW'(1));
    assign last_a  = AW'(r_count - CW'(1));
    assign key_hit = (i_rdata.key == r_new.key);

    always_comb begin
        rec_in.key       = i_req.entry_key;
        rec_in.name_low  = i_req.name_low;
        rec_in.name_mid  = i_req.name_mid;
        rec_in.name_high = i_req.name_high;
        rec_in.age       = i_req.age_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_new    <= n_new;
        r_ra     <= n_ra;
        r_stop   <= n_stop;
        r_status <= n_status;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_rec    <= n_rec;
    end

    // Next state and datapath registers. The RAM reads n_ra, so i_rdata
    // always holds the entry at r_ra.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_op     = r_op;
        n_new    = r_new;
        n_ra     = r_ra;
        n_stop   = r_stop;
        n_status = r_status;
        n_hit    = r_hit;
        n_found  = r_found;
        n_rec    = r_rec;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.op;
                    n_new    = rec_in;
                    n_status = ST_OK;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    n_state  = S_DONE;
                    case (i_req.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (!pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_ra    = last_a;
                                n_stop  = pos_a;
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (!pos_ok) begin
                                n_status = ST_BADPOS;
                            end else if (pos_x == cnt_x) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_ra    = AW'(pos_x);
                                n_stop  = last_a;
                                n_state = S_SHIFT;
                            end
                        end
                        OP_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_ra    = pos_a;
                                n_state = S_RDWAIT;
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_ra    = '0;
                                n_stop  = last_a;
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Move one entry per cycle; insert walks down, delete walks up.
                if (r_ra == r_stop) begin
                    if (r_op == OP_INSERT) begin
                        n_state = S_PUT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end else if (r_op == OP_INSERT) begin
                    n_ra = r_ra - AW'(1);
                end else begin
                    n_ra = r_ra + AW'(1);
                end
            end
            S_PUT: begin
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_RDWAIT: begin
                n_rec   = i_rdata;
                n_hit   = 1'b1;
                n_state = S_DONE;
            end
            S_FIND: begin
                if (key_hit) begin
                    n_rec   = i_rdata;
                    n_hit   = 1'b1;
                    n_found = CW'(r_ra) + CW'(1);
                    n_state = S_DONE;
                end else if (r_ra == r_stop) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_ra = r_ra + AW'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and RAM access.
    always_comb begin
        o_req_ready  = 1'b0;
        o_done       = 1'b0;
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_ra;
        o_ram.wdata  = i_rdata;
        o_ram.raddr  = n_ra;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid && (i_req.op == OP_APPEND) && !full) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = AW'(r_count);
                    o_ram.wdata = rec_in;
                end
            end
            S_SHIFT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = (r_op == OP_INSERT) ? (r_ra + AW'(1)) : (r_ra - AW'(1));
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_stop;
                o_ram.wdata = r_new;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.status         = r_status;
        o_rsp.found_position = PW'(r_found);
        o_rsp.out_key        = r_hit ? r_rec.key : '0;
        o_rsp.out_name_low   = r_hit ? r_rec.name_low : '0;
        o_rsp.out_name_mid   = r_hit ? r_rec.name_mid : '0;
        o_rsp.out_name_high  = r_hit ? r_rec.name_high : '0;
        o_rsp.out_age        = r_hit ? r_rec.age : '0;
        o_rsp.list_length    = PW'(r_count);
    end

    `SLT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `SLT_ASSERT_IMP(a_write_range, o_ram.we, CW'(o_ram.waddr) <= r_count, "write past list end")
    `SLT_ASSERT_NXT(a_hold_result, (r_state == S_DONE) && !i_res_ready, (r_state == S_DONE) && $stable(r_count), "result dropped while stalled")
    `SLT_ASSERT_IMP(a_hit_status, o_done && r_hit, r_status == ST_OK, "record returned with error status")

endmodule

`default_nettype wire

### tb/sltab_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequential list table checker
// Watches the request and result channels, keeps its own copy of the table,
// predicts one result per accepted request and compares every result beat
// field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------

module sltab_list_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sltab_req_if      req_ch,
    sltab_rsp_if      rsp_ch,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_entry_count
);
    import sltab_pkg::*;

    t_rec stored_recs [DEPTH];
    int   stored_count  = 0;
    int   fail_count    = 0;
    int   pending_count = 0;
    t_rsp expected_results [$];

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_entry_count = stored_count;

    function automatic t_rsp with_record(input t_rsp rs, input t_rec rec);
        rs.out_key       = rec.key;
        rs.out_name_low  = rec.name_low;
        rs.out_name_mid  = rec.name_mid;
        rs.out_name_high = rec.name_high;
        rs.out_age       = rec.age;
        return rs;
    endfunction

    // Apply one operation to the shadow table and return its result.
    function automatic t_rsp apply_list_op(input t_req rq);
        t_rsp rs;
        t_rec fresh;
        int   pos;
        rs              = '0;
        rs.status       = ST_OK;
        pos             = int'(rq.position);
        fresh.key       = rq.entry_key;
        fresh.name_low  = rq.name_low;
        fresh.name_mid  = rq.name_mid;
        fresh.name_high = rq.name_high;
        fresh.age       = rq.age_in;
        case (rq.op)
            OP_CLEAR: begin
                stored_count = 0;
            end
            OP_APPEND: begin
                if (stored_count >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    stored_recs[stored_count] = fresh;
                    stored_count++;
                end
            end
            OP_INSERT: begin
                if (stored_count >= DEPTH) begin
                    rs.status = ST_FULL;
                end else if (pos < 1 || pos > stored_count) begin
                    rs.status = ST_BADPOS;
                end else begin
                    // open a slot: shift the tail up by one
                    for (int i = stored_count; i >= pos; i--)
                        stored_recs[i] = stored_recs[i-1];
                    stored_recs[pos-1] = fresh;
                    stored_count++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > stored_count) begin
                    rs.status = ST_BADPOS;
                end else begin
                    for (int i = pos - 1; i + 1 < stored_count; i++)
                        stored_recs[i] = stored_recs[i+1];
                    stored_count--;
                end
            end
            OP_READ: begin
                if (pos < 1 || pos > stored_count)
                    rs.status = ST_BADPOS;
                else
                    rs = with_record(rs, stored_recs[pos-1]);
            end
            OP_FIND: begin
                rs.status = ST_NOTFOUND;
                for (int i = 0; i < stored_count; i++) begin
                    if (stored_recs[i].key == rq.entry_key) begin
                        rs.status         = ST_OK;
                        rs.found_position = PW'(i + 1);
                        rs = with_record(rs, stored_recs[i]);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        rs.list_length = PW'(stored_count);
        return rs;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            stored_count = 0;
            expected_results.delete();
        end else begin
            // retire the result first: it never belongs to this edge's request
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("found_position", 64'(want.found_position),
                                64'(got.found_position));
                    check_field("out_key", want.out_key, got.out_key);
                    check_field("out_name_low", want.out_name_low, got.out_name_low);
                    check_field("out_name_mid", want.out_name_mid, got.out_name_mid);
                    check_field("out_name_high", 64'(want.out_name_high),
                                64'(got.out_name_high));
                    check_field("out_age", 64'(want.out_age), 64'(got.out_age));
                    check_field("list_length", 64'(want.list_length),
                                64'(got.list_length));
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(apply_list_op(req_ch.payload));
        end
        pending_count = expected_results.size();
    end

endmodule

### tb/sequential_list_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequential list table testbench
// Drives directed and random table operations with random idling on both
// channels and one long result hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------

module sequential_list_table_tb;
    import sltab_pkg::*;

    localparam int          IDLE_PCT     = 18;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = DEPTH + 8;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
    localparam logic [63:0] ALL_ONES     = {64{1'b1}};

    typedef enum {PH_FILL, PH_PACKED, PH_GROW, PH_MIXED, PH_SHRINK} t_mix;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   entry_count;
    int   sent_count  = 0;
    int   cycle_count = 0;
    bit   quiet_phase = 1'b0;
    bit   held_off    = 1'b0;

    sltab_req_if req_bus ();
    sltab_rsp_if rsp_bus ();

    sequential_list_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sltab_list_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_ch        (req_bus),
        .rsp_ch        (rsp_bus),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_entry_count (entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic t_req build_req(input logic [2:0] op, input logic [7:0] pos,
                                       input logic [63:0] key);
        t_req rq;
        rq.op        = op;
        rq.position  = pos;
        rq.entry_key = key;
        rq.name_low  = {$urandom, $urandom};
        rq.name_mid  = {$urandom, $urandom};
        rq.name_high = $urandom;
        rq.age_in    = 8'($urandom_range(255));
        return rq;
    endfunction

    // Mostly a small pool so that finds hit, else any 64-bit key.
    function automatic logic [63:0] pick_key();
        if ($urandom_range(99) < 60)
            return 64'($urandom_range(15));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_position(input int len);
        int roll;
        roll = $urandom_range(99);
        if (len > 0 && roll < 85)
            return 8'($urandom_range(len, 1));
        if (roll < 90)
            return 8'd0;
        if (roll < 95)
            return 8'(len + 1);
        return 8'($urandom_range(255));
    endfunction

    function automatic t_req random_req(input t_mix mix, input int len);
        int         roll;
        logic [2:0] op;
        roll = $urandom_range(99);
        case (mix)
            PH_FILL:
                op = (roll < 65) ? OP_APPEND : (roll < 90) ? OP_INSERT :
                     (roll < 95) ? OP_FIND : OP_READ;
            PH_PACKED:
                op = (roll < 35) ? OP_APPEND : (roll < 60) ? OP_INSERT :
                     (roll < 80) ? OP_FIND : (roll < 90) ? OP_READ : OP_DELETE;
            PH_GROW:
                op = (roll < 40) ? OP_APPEND : (roll < 65) ? OP_INSERT :
                     (roll < 75) ? OP_FIND : (roll < 85) ? OP_READ :
                     (roll < 92) ? OP_DELETE : OP_SPARE_LO;
            PH_SHRINK:
                op = (roll < 10) ? OP_APPEND : (roll < 15) ? OP_INSERT :
                     (roll < 60) ? OP_DELETE : (roll < 75) ? OP_FIND :
                     (roll < 90) ? OP_READ : OP_SPARE_HI;
            default:
                op = (roll < 20) ? OP_APPEND : (roll < 40) ? OP_INSERT :
                     (roll < 58) ? OP_DELETE : (roll < 76) ? OP_FIND :
                     (roll < 94) ? OP_READ : (roll < 96) ? OP_SPARE_LO :
                     (roll < 97) ? OP_CLEAR : 3'($urandom_range(7));
        endcase
        if (op == OP_INSERT || op == OP_DELETE || op == OP_READ)
            return build_req(op, pick_position(len), pick_key());
        return build_req(op, 8'($urandom_range(255)), pick_key());
    endfunction

    function automatic t_mix window_mix(input int n);
        case ((n / 50) % 4)
            0:       return PH_GROW;
            2:       return PH_SHRINK;
            default: return PH_MIXED;
        endcase
    endfunction

    // Enter and leave at a falling edge; valid stays high after a beat unless the next item idles first.
    task automatic offer_item(input t_req rq);
        while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid   = 1'b1;
        req_bus.payload = rq;
        do @(posedge i_clk); while (!req_bus.ready);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic offer_op(input logic [2:0] op, input logic [7:0] pos,
                            input logic [63:0] key);
        offer_item(build_req(op, pos, key));
    endtask

    // Result side: random stalls, one long hold-off to back up the block.
    initial begin
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_off && sent_count >= HOLD_AT) begin
                rsp_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held_off = 1'b1;
            end else begin
                rsp_bus.ready = quiet_phase || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_req rq;
        t_mix mix;
        int   packed_left;
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty table
        offer_op(OP_READ,   8'd1, 64'd0);
        offer_op(OP_INSERT, 8'd1, 64'd1);
        offer_op(OP_DELETE, 8'd1, 64'd0);
        offer_op(OP_FIND,   8'd0, 64'd0);
        // extreme records
        rq = build_req(OP_APPEND, 8'hFF, ALL_ONES);
        rq.name_low  = ALL_ONES;
        rq.name_mid  = ALL_ONES;
        rq.name_high = '1;
        rq.age_in    = '1;
        offer_item(rq);
        rq = '0;
        rq.op = OP_APPEND;
        offer_item(rq);
        offer_op(OP_APPEND, 8'd0, 64'd5);
        // insert at the front and before the last entry
        offer_op(OP_INSERT, 8'd1, 64'd7);
        offer_op(OP_INSERT, 8'd4, 64'd9);
        offer_op(OP_INSERT, 8'd0, 64'd3);
        offer_op(OP_INSERT, 8'd6, 64'd3);
        offer_op(OP_READ,   8'd1, 64'd0);
        offer_op(OP_READ,   8'd5, 64'd0);
        offer_op(OP_READ,   8'd0, 64'd0);
        offer_op(OP_READ,   8'hFF, 64'd0);
        // duplicate key: find must report the first one
        offer_op(OP_APPEND, 8'd0, 64'd0);
        offer_op(OP_FIND,   8'd0, 64'd0);
        offer_op(OP_FIND,   8'd0, ALL_ONES);
        offer_op(OP_FIND,   8'd0, 64'h1234_5678_9ABC_DEF0);
        // delete first, last and middle, then one past the end
        offer_op(OP_DELETE, 8'd1, 64'd0);
        offer_op(OP_DELETE, 8'd5, 64'd0);
        offer_op(OP_DELETE, 8'd2, 64'd0);
        offer_op(OP_DELETE, 8'd4, 64'd0);
        offer_op(OP_SPARE_LO, 8'd1, 64'd0);
        offer_op(OP_SPARE_HI, 8'd2, 64'd1);
        offer_op(OP_CLEAR,  8'd0, 64'd0);
        offer_op(OP_READ,   8'd1, 64'd0);

        // fill to capacity, push against the full table, then mixed windows
        mix         = PH_FILL;
        packed_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_phase = (n >= 420 && n < 500);
            if (mix == PH_FILL) begin
                if (entry_count == DEPTH) begin
                    mix         = PH_PACKED;
                    packed_left = 16;
                end
            end else if (mix == PH_PACKED) begin
                if (packed_left == 0)
                    mix = window_mix(n);
            end else begin
                mix = window_mix(n);
            end
            if (mix == PH_PACKED)
                packed_left--;
            offer_item(random_req(mix, entry_count));
        end
        quiet_phase   = 1'b0;
        req_bus.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
